FILE: design/dmts_pkg.sv
// Shared constants, types and the standard size list of the display mode table search.
// No dependencies; every other file of the block but dmts_ram imports this package.
package dmts_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths.
   localparam int ID_W    = 16;
   localparam int SIZE_W  = 13;
   localparam int FUNC_W  = 3;
   localparam int COST_W  = SIZE_W + 1;
   localparam int OIDX_W  = 4;
   localparam int OCNT_W  = 5;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_USER_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIMARY_ID  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ALTERNATE_ID = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_ID   = 3'd6;

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_REBUILD = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_NEAREST = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_EXACT   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SET     = 3'd4;

   // Standard size list.
   localparam int STD_COUNT = 13;
   localparam int STD_IDX_W = $clog2(STD_COUNT);

   // One table entry as stored in the mode memory.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } entry_type;

   function automatic logic [SIZE_W-1:0] std_width(input logic [STD_IDX_W-1:0] idx);
      logic [SIZE_W-1:0] w;
      unique case (idx)
         4'd0:    w = 13'd512;
         4'd1:    w = 13'd640;
         4'd2:    w = 13'd800;
         4'd3:    w = 13'd832;
         4'd4:    w = 13'd1024;
         4'd5:    w = 13'd1152;
         4'd6:    w = 13'd1280;
         4'd7:    w = 13'd1280;
         4'd8:    w = 13'd1440;
         4'd9:    w = 13'd1600;
         4'd10:   w = 13'd1680;
         4'd11:   w = 13'd1920;
         4'd12:   w = 13'd1920;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [SIZE_W-1:0] std_height(input logic [STD_IDX_W-1:0] idx);
      logic [SIZE_W-1:0] h;
      unique case (idx)
         4'd0:    h = 13'd384;
         4'd1:    h = 13'd480;
         4'd2:    h = 13'd600;
         4'd3:    h = 13'd624;
         4'd4:    h = 13'd768;
         4'd5:    h = 13'd870;
         4'd6:    h = 13'd800;
         4'd7:    h = 13'd1024;
         4'd8:    h = 13'd900;
         4'd9:    h = 13'd1000;
         4'd10:   h = 13'd1050;
         4'd11:   h = 13'd1080;
         4'd12:   h = 13'd1200;
         default: h = '0;
      endcase
      return h;
   endfunction

endpackage

FILE: design/dmts_req_if.sv
// Request channel of the display mode table search: valid, ready and the request fields.
// Depends on dmts_pkg for the field widths.
interface dmts_req_if;
   import dmts_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   mode_id;
   logic [SIZE_W-1:0] req_width;
   logic [SIZE_W-1:0] req_height;

   modport source (output valid, output func, output mode_id, output req_width,
                   output req_height, input ready);
   modport sink   (input valid, input func, input mode_id, input req_width,
                   input req_height, output ready);
endinterface

FILE: design/dmts_rsp_if.sv
// Response channel of the display mode table search: valid, ready and the result fields.
// Depends on dmts_pkg for the field widths.
interface dmts_rsp_if;
   import dmts_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic [OIDX_W-1:0] entry_index;
   logic [ID_W-1:0]   result_id;
   logic [SIZE_W-1:0] entry_width;
   logic [SIZE_W-1:0] entry_height;
   logic [OCNT_W-1:0] entry_count;
   logic [ID_W-1:0]   next_dynamic_id;

   modport source (output valid, output found, output entry_index, output result_id,
                   output entry_width, output entry_height, output entry_count,
                   output next_dynamic_id, input ready);
   modport sink   (input valid, input found, input entry_index, input result_id,
                   input entry_width, input entry_height, input entry_count,
                   input next_dynamic_id, output ready);
endinterface

FILE: design/dmts_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dmts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/display_mode_table_search.sv
// Display mode table search: a table of display modes kept in one synchronous memory.
// Depends on dmts_pkg, dmts_req_if, dmts_rsp_if and dmts_ram.
//
// Usage:
//   A request on req_port carries func, mode_id, req_width and req_height. Rebuild fills
//   the table with two dynamic entries at the user size and the standard sizes that fit.
//   Find, nearest, exact and set scan the valid entries one per cycle through the mode
//   memory's single read port; a set that hits then writes the new size back.
//   Each request yields exactly one response on rsp_port.
//   Rebuild writes the two dynamic entries, then steps through the thirteen standard sizes.
//   Throughput: one request at a time; the next request is taken once the current one has
//   reached the response register, so a response can wait while the next request runs.
//   If the receiver stalls and a finished result finds the response register still full,
//   the block holds that result and takes no new request until the register frees up.
//   Reset empties the table by clearing the entry count; the memory itself is not cleared,
//   since entries past the count are never read. Configuration registers take their boot
//   values. The csr port writes one register per cycle and must be used while idle.
module display_mode_table_search (
   input  logic                          clock,
   input  logic                          reset,
   dmts_req_if.sink                      req_port,
   dmts_rsp_if.source                    rsp_port,
   input  logic                          csr_we,
   input  logic [dmts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dmts_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dmts_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_REB_DYN = 3'd1;
   localparam logic [2:0] ST_REB_STD = 3'd2;
   localparam logic [2:0] ST_SCAN    = 3'd3;
   localparam logic [2:0] ST_WRITE   = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // Configuration registers.
   logic [SIZE_W-1:0] user_width_ff, user_height_ff, max_width_ff, max_height_ff;
   logic [ID_W-1:0]   primary_id_ff, alternate_id_ff, active_id_ff;

   // Control state.
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] valid_count_ff, valid_count_in;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working payload.
   logic [IDX_W-1:0]     pend_idx_ff, pend_idx_in;
   logic [STD_IDX_W-1:0] std_idx_ff, std_idx_in;
   logic [ID_W-1:0]      next_id_ff, next_id_in;
   logic [FUNC_W-1:0]    op_func_ff, op_func_in;
   logic [ID_W-1:0]      op_id_ff, op_id_in;
   logic [SIZE_W-1:0]    op_w_ff, op_w_in, op_h_ff, op_h_in;
   logic                 found_ff, found_in, any_ff, any_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [ID_W-1:0]      rid_ff, rid_in;
   logic [SIZE_W-1:0]    ew_ff, ew_in, eh_ff, eh_in;
   logic [COST_W-1:0]    best_ff, best_in;

   // Response register.
   logic              o_found_ff, o_found_in;
   logic [OIDX_W-1:0] o_idx_ff, o_idx_in;
   logic [ID_W-1:0]   o_rid_ff, o_rid_in;
   logic [SIZE_W-1:0] o_w_ff, o_w_in, o_h_ff, o_h_in;
   logic [OCNT_W-1:0] o_cnt_ff, o_cnt_in;
   logic [ID_W-1:0]   o_next_ff, o_next_in;

   // Memory port signals.
   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data;

   // Per-cycle helpers.
   logic [SIZE_W-1:0] std_w, std_h, dw, dh;
   logic              std_skip;
   logic [COST_W-1:0] cost;
   logic              req_fire;

   dmts_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_mode_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;

   // Standard size candidate and the distance of the returned entry.
   always_comb begin
      std_w    = std_width(std_idx_ff);
      std_h    = std_height(std_idx_ff);
      std_skip = (std_w > max_width_ff) || (std_h > max_height_ff) ||
                 ((std_w == user_width_ff) && (std_h == user_height_ff));
      dw       = (rd_data.width > op_w_ff) ? rd_data.width - op_w_ff
                                          : op_w_ff - rd_data.width;
      dh       = (rd_data.height > op_h_ff) ? rd_data.height - op_h_ff
                                           : op_h_ff - rd_data.height;
      cost     = COST_W'(dw) + COST_W'(dh);
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      valid_count_in = valid_count_ff;
      ptr_in         = ptr_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      std_idx_in     = std_idx_ff;
      next_id_in     = next_id_ff;
      op_func_in     = op_func_ff;
      op_id_in       = op_id_ff;
      op_w_in        = op_w_ff;
      op_h_in        = op_h_ff;
      found_in       = found_ff;
      any_in         = any_ff;
      idx_in         = idx_ff;
      rid_in         = rid_ff;
      ew_in          = ew_ff;
      eh_in          = eh_ff;
      best_in        = best_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_port.ready;
      o_found_in     = o_found_ff;
      o_idx_in       = o_idx_ff;
      o_rid_in       = o_rid_ff;
      o_w_in         = o_w_ff;
      o_h_in         = o_h_ff;
      o_cnt_in       = o_cnt_ff;
      o_next_in      = o_next_ff;
      wr_en          = 1'b0;
      wr_addr        = ptr_ff[IDX_W-1:0];
      wr_data        = '{id: next_id_ff, width: std_w, height: std_h};
      rd_en          = 1'b0;
      rd_addr        = ptr_ff[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_func_in = req_port.func;
               op_id_in   = req_port.mode_id;
               op_w_in    = req_port.req_width;
               op_h_in    = req_port.req_height;
               found_in   = 1'b0;
               any_in     = 1'b0;
               idx_in     = '0;
               rid_in     = '0;
               ew_in      = '0;
               eh_in      = '0;
               best_in    = '0;
               ptr_in     = '0;
               std_idx_in = '0;
               next_id_in = alternate_id_ff + 1'b1;
               priority if (req_port.func == FUNC_REBUILD) begin
                  state_in = ST_REB_DYN;
               end else if ((req_port.func == FUNC_FIND) || (req_port.func == FUNC_SET) ||
                            (req_port.func == FUNC_NEAREST) ||
                            (req_port.func == FUNC_EXACT)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end

         // The two dynamic entries at the user size.
         ST_REB_DYN: begin
            wr_en   = 1'b1;
            wr_data = '{id: (ptr_ff == '0) ? primary_id_ff : alternate_id_ff,
                        width: user_width_ff, height: user_height_ff};
            ptr_in  = ptr_ff + 1'b1;
            if (ptr_ff != '0) begin
               state_in = ST_REB_STD;
            end
         end

         // One standard size per cycle; sizes that do not fit or equal the user size are passed over.
         ST_REB_STD: begin
            if (!std_skip && (ptr_ff < DEPTH_CNT)) begin
               wr_en      = 1'b1;
               ptr_in     = ptr_ff + 1'b1;
               next_id_in = next_id_ff + 1'b1;
            end
            std_idx_in = std_idx_ff + 1'b1;
            if (std_idx_ff == STD_IDX_W'(STD_COUNT - 1)) begin
               valid_count_in = ptr_in;
               state_in       = ST_DONE;
            end
         end

         // Read one entry per cycle and weigh the one returned by the memory.
         ST_SCAN: begin
            if (ptr_ff < valid_count_ff) begin
               rd_en       = 1'b1;
               ptr_in      = ptr_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = ptr_ff[IDX_W-1:0];
            end
            if (pend_ff) begin
               priority case (op_func_ff)
                  FUNC_FIND, FUNC_SET: begin
                     if (!found_ff && (rd_data.id == op_id_ff)) begin
                        found_in = 1'b1;
                        idx_in   = pend_idx_ff;
                        rid_in   = rd_data.id;
                        ew_in    = (op_func_ff == FUNC_SET) ? op_w_ff : rd_data.width;
                        eh_in    = (op_func_ff == FUNC_SET) ? op_h_ff : rd_data.height;
                     end
                  end
                  FUNC_NEAREST: begin
                     if (!any_ff || (cost < best_ff)) begin
                        any_in  = 1'b1;
                        best_in = cost;
                        idx_in  = pend_idx_ff;
                        rid_in  = rd_data.id;
                        ew_in   = rd_data.width;
                        eh_in   = rd_data.height;
                     end
                  end
                  FUNC_EXACT: begin
                     if (!found_ff && (rd_data.id != primary_id_ff) &&
                         (rd_data.id != alternate_id_ff) &&
                         (rd_data.width == op_w_ff) && (rd_data.height == op_h_ff)) begin
                        found_in = 1'b1;
                        idx_in   = pend_idx_ff;
                        rid_in   = rd_data.id;
                        ew_in    = rd_data.width;
                        eh_in    = rd_data.height;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (ptr_ff >= valid_count_ff) begin
               state_in = ((op_func_ff == FUNC_SET) && found_ff) ? ST_WRITE : ST_DONE;
            end
         end

         // Write the new size of a located entry back; its id stays.
         ST_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = '{id: rid_ff, width: op_w_ff, height: op_h_ff};
            state_in = ST_DONE;
         end

         // Hand the result to the response register once it is free.
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               o_found_in   = found_ff;
               o_idx_in     = OIDX_W'(idx_ff);
               o_rid_in     = rid_ff;
               o_w_in       = ew_ff;
               o_h_in       = eh_ff;
               o_cnt_in     = OCNT_W'(valid_count_ff);
               o_next_in    = (active_id_ff == primary_id_ff) ? alternate_id_ff
                                                              : primary_id_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         valid_count_ff  <= '0;
         ptr_ff          <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         user_width_ff   <= 13'd1024;
         user_height_ff  <= 13'd768;
         primary_id_ff   <= 16'd128;
         alternate_id_ff <= 16'd129;
         max_width_ff    <= 13'd1920;
         max_height_ff   <= 13'd1200;
         active_id_ff    <= 16'd128;
      end else begin
         state_ff       <= state_in;
         valid_count_ff <= valid_count_in;
         ptr_ff         <= ptr_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_USER_WIDTH:   user_width_ff   <= csr_wdata[SIZE_W-1:0];
               CSR_USER_HEIGHT:  user_height_ff  <= csr_wdata[SIZE_W-1:0];
               CSR_PRIMARY_ID:   primary_id_ff   <= csr_wdata[ID_W-1:0];
               CSR_ALTERNATE_ID: alternate_id_ff <= csr_wdata[ID_W-1:0];
               CSR_MAX_WIDTH:    max_width_ff    <= csr_wdata[SIZE_W-1:0];
               CSR_MAX_HEIGHT:   max_height_ff   <= csr_wdata[SIZE_W-1:0];
               CSR_ACTIVE_ID:    active_id_ff    <= csr_wdata[ID_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      std_idx_ff  <= std_idx_in;
      next_id_ff  <= next_id_in;
      op_func_ff  <= op_func_in;
      op_id_ff    <= op_id_in;
      op_w_ff     <= op_w_in;
      op_h_ff     <= op_h_in;
      found_ff    <= found_in;
      any_ff      <= any_in;
      idx_ff      <= idx_in;
      rid_ff      <= rid_in;
      ew_ff       <= ew_in;
      eh_ff       <= eh_in;
      best_ff     <= best_in;
      o_found_ff  <= o_found_in;
      o_idx_ff    <= o_idx_in;
      o_rid_ff    <= o_rid_in;
      o_w_ff      <= o_w_in;
      o_h_ff      <= o_h_in;
      o_cnt_ff    <= o_cnt_in;
      o_next_ff   <= o_next_in;
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.found           = o_found_ff;
   assign rsp_port.entry_index     = o_idx_ff;
   assign rsp_port.result_id       = o_rid_ff;
   assign rsp_port.entry_width     = o_w_ff;
   assign rsp_port.entry_height    = o_h_ff;
   assign rsp_port.entry_count     = o_cnt_ff;
   assign rsp_port.next_dynamic_id = o_next_ff;

endmodule

FILE: design/dmts_checker.sv
// Port-level checks for the display mode table search, bound to the top level.
// Depends on dmts_pkg and on the port names of display_mode_table_search.
module dmts_port_checks (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_found,
   input logic [dmts_pkg::OCNT_W-1:0] rsp_entry_count
);
   import dmts_pkg::*;

   // Nothing is offered right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   // One request at a time: the block is busy right after taking one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is running");

   // A located entry implies a non-empty table.
   a_found_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_entry_count != '0))
      else $error("entry found in an empty table");

   // The entry count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (OCNT_W'(TABLE_DEPTH) == '0 ||
                     rsp_entry_count <= OCNT_W'(TABLE_DEPTH)))
      else $error("entry count above table depth");

endmodule

bind display_mode_table_search dmts_port_checks u_dmts_port_checks (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_found       (rsp_port.found),
   .rsp_entry_count (rsp_port.entry_count)
);

FILE: sim/dmts_checker.sv
// Checker for the display mode table search: keeps its own copy of the mode table and registers.
// Depends on dmts_pkg and on the dmts_req_if and dmts_rsp_if channel interfaces.
// It watches both channels and the csr port, predicts each response and counts mismatches.
module dmts_checker
   import dmts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dmts_req_if                   req_ch,
   dmts_rsp_if                   rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending_count,
   output int                    checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // One predicted response, laid out like the response channel.
   typedef struct packed {
      logic              found;
      logic [OIDX_W-1:0] index;
      logic [ID_W-1:0]   mode_id;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      logic [OCNT_W-1:0] count;
      logic [ID_W-1:0]   next_id;
   } search_answer;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      search_answer      answer;
   } awaited_answer;

   // Standard sizes offered by a rebuild, in table order.
   int standard_widths [STD_COUNT] = '{512, 640, 800, 832, 1024, 1152, 1280, 1280, 1440,
                                       1600, 1680, 1920, 1920};
   int standard_heights [STD_COUNT] = '{384, 480, 600, 624, 768, 870, 800, 1024, 900,
                                        1000, 1050, 1080, 1200};

   // Mirrored registers.
   logic [SIZE_W-1:0] user_w, user_h, limit_w, limit_h;
   logic [ID_W-1:0]   primary_id, alternate_id, active_id;

   // Mirrored mode table.
   logic [ID_W-1:0]   mode_ids     [TABLE_DEPTH];
   logic [SIZE_W-1:0] mode_widths  [TABLE_DEPTH];
   logic [SIZE_W-1:0] mode_heights [TABLE_DEPTH];
   int                mode_count;

   awaited_answer answers_due [$];

   task automatic report_mismatch(input string text);
      if (fail_count < 50) begin
         $display("%0t ns mismatch: %s", $time, text);
      end
      fail_count++;
   endtask

   // Two dynamic entries at the user size, then the standard sizes that fit.
   function automatic void rebuild_table();
      int               n;
      logic [ID_W-1:0]  next_id;
      mode_ids[0]     = primary_id;
      mode_widths[0]  = user_w;
      mode_heights[0] = user_h;
      mode_ids[1]     = alternate_id;
      mode_widths[1]  = user_w;
      mode_heights[1] = user_h;
      n       = 2;
      next_id = alternate_id + 1'b1;
      for (int i = 0; i < STD_COUNT; i++) begin
         if (standard_widths[i] > int'(limit_w) || standard_heights[i] > int'(limit_h)) begin
            continue;
         end
         if (standard_widths[i] == int'(user_w) && standard_heights[i] == int'(user_h)) begin
            continue;
         end
         if (n >= TABLE_DEPTH) begin
            break;
         end
         mode_ids[n]     = next_id;
         mode_widths[n]  = SIZE_W'(standard_widths[i]);
         mode_heights[n] = SIZE_W'(standard_heights[i]);
         next_id         = next_id + 1'b1;
         n++;
      end
      mode_count = n;
   endfunction

   // Applies one request to the mirrored table and returns the response it should give.
   function automatic search_answer search_table(input logic [FUNC_W-1:0] func,
                                                 input logic [ID_W-1:0]   id,
                                                 input logic [SIZE_W-1:0] w,
                                                 input logic [SIZE_W-1:0] h);
      search_answer a;
      int           hit;
      int           best;
      int           dw;
      int           dh;
      a   = '0;
      hit = -1;
      case (func)
         FUNC_REBUILD: begin
            rebuild_table();
         end
         FUNC_FIND, FUNC_SET: begin
            // The lowest index wins when ids repeat.
            for (int i = 0; i < mode_count; i++) begin
               if (hit < 0 && mode_ids[i] == id) hit = i;
            end
            if (hit >= 0) begin
               if (func == FUNC_SET) begin
                  mode_widths[hit]  = w;
                  mode_heights[hit] = h;
               end
               a.found = 1'b1;
            end
         end
         FUNC_NEAREST: begin
            // Least Manhattan distance; a strict compare keeps the first entry on a tie.
            best = -1;
            for (int i = 0; i < mode_count; i++) begin
               dw = int'(mode_widths[i]) - int'(w);
               dh = int'(mode_heights[i]) - int'(h);
               if (dw < 0) dw = -dw;
               if (dh < 0) dh = -dh;
               if (hit < 0 || dw + dh < best) begin
                  best = dw + dh;
                  hit  = i;
               end
            end
         end
         FUNC_EXACT: begin
            // Dynamic ids never count as a standard match.
            for (int i = 0; i < mode_count; i++) begin
               if (hit < 0 && mode_ids[i] != primary_id && mode_ids[i] != alternate_id &&
                   mode_widths[i] == w && mode_heights[i] == h) begin
                  hit = i;
               end
            end
            if (hit >= 0) a.found = 1'b1;
         end
         default: begin
         end
      endcase
      if (hit >= 0 && func != FUNC_REBUILD) begin
         a.index   = OIDX_W'(hit);
         a.mode_id = mode_ids[hit];
         a.width   = mode_widths[hit];
         a.height  = mode_heights[hit];
      end
      a.count   = OCNT_W'(mode_count);
      a.next_id = (active_id == primary_id) ? alternate_id : primary_id;
      return a;
   endfunction

   task automatic compare_answer(input awaited_answer due);
      string tag;
      tag = $sformatf("response %0d (func %0d)", checked_count, due.func);
      if (rsp_ch.found !== due.answer.found) begin
         report_mismatch($sformatf("%s found %0d, expected %0d", tag, rsp_ch.found,
                                   due.answer.found));
      end
      if (rsp_ch.entry_index !== due.answer.index) begin
         report_mismatch($sformatf("%s entry_index %0d, expected %0d", tag,
                                   rsp_ch.entry_index, due.answer.index));
      end
      if (rsp_ch.result_id !== due.answer.mode_id) begin
         report_mismatch($sformatf("%s result_id %0d, expected %0d", tag, rsp_ch.result_id,
                                   due.answer.mode_id));
      end
      if (rsp_ch.entry_width !== due.answer.width) begin
         report_mismatch($sformatf("%s entry_width %0d, expected %0d", tag,
                                   rsp_ch.entry_width, due.answer.width));
      end
      if (rsp_ch.entry_height !== due.answer.height) begin
         report_mismatch($sformatf("%s entry_height %0d, expected %0d", tag,
                                   rsp_ch.entry_height, due.answer.height));
      end
      if (rsp_ch.entry_count !== due.answer.count) begin
         report_mismatch($sformatf("%s entry_count %0d, expected %0d", tag,
                                   rsp_ch.entry_count, due.answer.count));
      end
      if (rsp_ch.next_dynamic_id !== due.answer.next_id) begin
         report_mismatch($sformatf("%s next_dynamic_id %0d, expected %0d", tag,
                                   rsp_ch.next_dynamic_id, due.answer.next_id));
      end
      checked_count++;
   endtask

   // Sample both channels and the csr port at every rising edge.
   always @(posedge clock) begin : watch_channels
      awaited_answer due;
      if (reset) begin
         user_w        = 13'd1024;
         user_h        = 13'd768;
         primary_id    = 16'd128;
         alternate_id  = 16'd129;
         limit_w       = 13'd1920;
         limit_h       = 13'd1200;
         active_id     = 16'd128;
         mode_count    = 0;
         fail_count    = 0;
         checked_count = 0;
         answers_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_USER_WIDTH:   user_w       = csr_wdata[SIZE_W-1:0];
               CSR_USER_HEIGHT:  user_h       = csr_wdata[SIZE_W-1:0];
               CSR_PRIMARY_ID:   primary_id   = csr_wdata;
               CSR_ALTERNATE_ID: alternate_id = csr_wdata;
               CSR_MAX_WIDTH:    limit_w      = csr_wdata[SIZE_W-1:0];
               CSR_MAX_HEIGHT:   limit_h      = csr_wdata[SIZE_W-1:0];
               CSR_ACTIVE_ID:    active_id    = csr_wdata;
               default: begin
               end
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               due = answers_due.pop_front();
               compare_answer(due);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            due.func   = req_ch.func;
            due.answer = search_table(req_ch.func, req_ch.mode_id, req_ch.req_width,
                                      req_ch.req_height);
            answers_due.push_back(due);
         end
      end
      pending_count = answers_due.size();
   end

endmodule

FILE: sim/testbench.sv
// Top of the display mode table search testbench: clock, reset, request stimulus and verdict.
// Depends on dmts_pkg, both channel interfaces, the block itself and dmts_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dmts_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT     = 3000;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 62;
   localparam int CSR_COUNT       = int'(CSR_ACTIVE_ID) + 1;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = FUNC_SET + 1'b1;

   typedef struct {
      logic [SIZE_W-1:0] user_w;
      logic [SIZE_W-1:0] user_h;
      logic [ID_W-1:0]   primary;
      logic [ID_W-1:0]   alternate;
      logic [SIZE_W-1:0] max_w;
      logic [SIZE_W-1:0] max_h;
      logic [ID_W-1:0]   active;
   } register_set;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int                    checked_count;

   bit          idling_on;
   bit          hold_off_wanted;
   register_set regs;
   int          register_loads;
   int          quiet_cycles;
   int          requests_by_func [8];

   dmts_req_if req_ch ();
   dmts_rsp_if rsp_ch ();

   display_mode_table_search i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_ch),
      .rsp_port  (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dmts_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always #5 clock = ~clock;

   // End the run when neither channel has moved for too long.
   always @(posedge clock) begin : watchdog
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no request or response moved for %0d cycles.", QUIET_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   // Response side: random stall bursts, plus one long hold-off on demand.
   initial begin : response_side
      int burst;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_wanted) begin
            hold_off_wanted = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 14);
            rsp_ch.ready <= 1'b0;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic register_set make_registers(input int uw, input int uh, input int p,
                                                  input int a, input int mw, input int mh,
                                                  input int act);
      register_set r;
      r.user_w    = SIZE_W'(uw);
      r.user_h    = SIZE_W'(uh);
      r.primary   = ID_W'(p);
      r.alternate = ID_W'(a);
      r.max_w     = SIZE_W'(mw);
      r.max_h     = SIZE_W'(mh);
      r.active    = ID_W'(act);
      return r;
   endfunction

   // A random register set; user and limit sizes often sit on a standard size.
   function automatic register_set random_registers();
      register_set r;
      int          k;
      k = $urandom_range(0, STD_COUNT - 1);
      if ($urandom_range(0, 2) == 0) begin
         r.user_w = std_width(STD_IDX_W'(k));
         r.user_h = std_height(STD_IDX_W'(k));
      end else begin
         r.user_w = SIZE_W'($urandom_range(1, 8191));
         r.user_h = SIZE_W'($urandom_range(1, 8191));
      end
      k = $urandom_range(0, STD_COUNT - 1);
      case ($urandom_range(0, 2))
         0: begin
            r.max_w = std_width(STD_IDX_W'(k));
            r.max_h = std_height(STD_IDX_W'(k));
         end
         1: begin
            r.max_w = SIZE_W'($urandom_range(1, 8191));
            r.max_h = SIZE_W'($urandom_range(1, 8191));
         end
         default: begin
            r.max_w = '1;
            r.max_h = '1;
         end
      endcase
      r.primary   = ID_W'($urandom_range(0, 65535));
      r.alternate = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 65535))
                                                : r.primary + 1'b1;
      case ($urandom_range(0, 2))
         0:       r.active = r.primary;
         1:       r.active = r.alternate;
         default: r.active = ID_W'($urandom_range(0, 65535));
      endcase
      return r;
   endfunction

   // Writes all seven registers on consecutive cycles; called only while the block is idle.
   task automatic load_registers(input register_set r);
      logic [CSR_DATA_W-1:0] values [CSR_COUNT];
      values[CSR_USER_WIDTH]   = CSR_DATA_W'(r.user_w);
      values[CSR_USER_HEIGHT]  = CSR_DATA_W'(r.user_h);
      values[CSR_PRIMARY_ID]   = r.primary;
      values[CSR_ALTERNATE_ID] = r.alternate;
      values[CSR_MAX_WIDTH]    = CSR_DATA_W'(r.max_w);
      values[CSR_MAX_HEIGHT]   = CSR_DATA_W'(r.max_h);
      values[CSR_ACTIVE_ID]    = r.active;
      for (int i = 0; i < CSR_COUNT; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= values[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      regs = r;
      register_loads++;
   endtask

   // Offers one request, with an optional idle gap first, and returns after it is taken.
   task automatic send_request(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                               input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      int gap;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 14);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.func       <= f;
      req_ch.mode_id    <= id;
      req_ch.req_width  <= w;
      req_ch.req_height <= h;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      requests_by_func[f]++;
   endtask

   // Stops offering and waits until every response has come back.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // A random request: ids mostly ones the table holds, sizes often standard ones.
   task automatic random_request();
      int                pick;
      int                k;
      logic [FUNC_W-1:0] f;
      logic [ID_W-1:0]   id;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      pick = $urandom_range(0, 99);
      if (pick < 5) f = FUNC_REBUILD;
      else if (pick < 30) f = FUNC_FIND;
      else if (pick < 50) f = FUNC_NEAREST;
      else if (pick < 72) f = FUNC_EXACT;
      else if (pick < 94) f = FUNC_SET;
      else f = FUNC_UNUSED_FIRST + FUNC_W'($urandom_range(0, 2));
      pick = $urandom_range(0, 19);
      if (pick == 0) id = regs.primary;
      else if (pick <= 14) id = regs.alternate + ID_W'(pick - 1);
      else id = ID_W'($urandom_range(0, 65535));
      pick = $urandom_range(0, 9);
      k    = $urandom_range(0, STD_COUNT - 1);
      if (pick < 4) begin
         w = std_width(STD_IDX_W'(k));
         h = std_height(STD_IDX_W'(k));
      end else if (pick == 4) begin
         w = regs.user_w;
         h = regs.user_h;
      end else begin
         w = SIZE_W'($urandom_range(0, 8191));
         h = SIZE_W'($urandom_range(0, 8191));
      end
      send_request(f, id, w, h);
   endtask

   // Directed requests on the boot registers: empty table first, then the rebuilt one.
   task automatic run_directed();
      send_request(FUNC_FIND, 16'd128, '0, '0);
      send_request(FUNC_NEAREST, '0, '0, '0);
      send_request(FUNC_EXACT, '0, 13'd1024, 13'd768);
      send_request(FUNC_SET, 16'd128, 13'd1, 13'd1);
      send_request(FUNC_REBUILD, '1, '1, '1);
      send_request(FUNC_FIND, 16'd128, '0, '0);
      send_request(FUNC_FIND, '1, '0, '0);
      send_request(FUNC_FIND, '0, '0, '0);
      // Both dynamic entries match; the first one must win.
      send_request(FUNC_NEAREST, '0, 13'd1024, 13'd768);
      send_request(FUNC_NEAREST, '0, '1, '1);
      send_request(FUNC_NEAREST, '0, '0, '0);
      // Equally far from 1280x800 and 1280x1024.
      send_request(FUNC_NEAREST, '0, 13'd1280, 13'd912);
      send_request(FUNC_EXACT, '0, 13'd640, 13'd480);
      // The user size is held only by the dynamic entries, so no standard match.
      send_request(FUNC_EXACT, '0, 13'd1024, 13'd768);
      send_request(FUNC_EXACT, '1, '1, '0);
      send_request(FUNC_SET, 16'd130, '1, '1);
      send_request(FUNC_FIND, 16'd130, '0, '0);
      send_request(FUNC_NEAREST, '0, '1, '1);
      send_request(FUNC_SET, '1, '0, '0);
      send_request(FUNC_EXACT, '0, '0, '1);
      send_request(FUNC_FIND, 16'd143, '0, '0);
      send_request(FUNC_UNUSED_FIRST, '1, '1, '1);
      send_request(FUNC_UNUSED_FIRST + 3'd1, '0, '0, '0);
      send_request(FUNC_UNUSED_FIRST + 3'd2, '1, '1, '1);
   endtask

   // Main stimulus: reset, directed part, then phases of random requests per register set.
   initial begin : stimulus
      register_set plan;
      int          unused_codes;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.func       = '0;
      req_ch.mode_id    = '0;
      req_ch.req_width  = '0;
      req_ch.req_height = '0;
      idling_on         = 1'b1;
      hold_off_wanted   = 1'b0;
      register_loads    = 0;
      quiet_cycles      = 0;
      regs = make_registers(1024, 768, 128, 129, 1920, 1200, 128);
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            // Smallest user size, ids at both ends so standard ids wrap onto the primary.
            0: plan = make_registers(1, 1, 0, 65535, 8191, 8191, 0);
            // Every standard size too large; only the two dynamic entries remain.
            1: plan = make_registers(8191, 8191, 65535, 65534, 1, 1, 65535);
            // User size on a standard size, both dynamic ids equal.
            2: plan = make_registers(1920, 1200, 7, 7, 1920, 1200, 65535);
            3: plan = make_registers(640, 480, 300, 301, 1600, 1000, 301);
            default: plan = random_registers();
         endcase
         load_registers(plan);
         // Let the block fill up behind a receiver that stops taking responses.
         if (phase == 1) hold_off_wanted = 1'b1;
         idling_on = !(phase == 5 || phase >= PHASES - 2);
         if ($urandom_range(0, 6) != 0) begin
            send_request(FUNC_REBUILD, ID_W'($urandom_range(0, 65535)),
                         SIZE_W'($urandom_range(0, 8191)), SIZE_W'($urandom_range(0, 8191)));
         end
         repeat (ITEMS_PER_PHASE) random_request();
      end

      settle();
      repeat (40) @(negedge clock);
      unused_codes = requests_by_func[5] + requests_by_func[6] + requests_by_func[7];
      $display("Sent %0d rebuild, %0d find, %0d nearest, %0d exact, %0d set and %0d unused-code",
               requests_by_func[FUNC_REBUILD], requests_by_func[FUNC_FIND],
               requests_by_func[FUNC_NEAREST], requests_by_func[FUNC_EXACT],
               requests_by_func[FUNC_SET], unused_codes);
      $display("requests over %0d register loads; %0d responses checked, %0d mismatches.",
               register_loads, checked_count, fail_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
